// ===== hw/rtl/pcbq_pkg.sv =====
package pcbq_pkg;

    typedef logic [1:0] func_t;
    localparam func_t FN_ENQ    = 2'd0;
    localparam func_t FN_DEL    = 2'd1;
    localparam func_t FN_LOOKUP = 2'd2;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_MISS  = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

    localparam logic [2:0] STATE_INVALID = 3'd5;

    typedef struct packed {
        logic [31:0] id;
        logic [2:0]  state_code;
        logic [31:0] timestamp;
    } rec_t;

    localparam rec_t REC_ZERO = '{id: 32'd0, state_code: 3'd0, timestamp: 32'd0};

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DCAP   = 5'b00010,
        S_DSHIFT = 5'b00100,
        S_LOOK   = 5'b01000,
        S_FIN    = 5'b10000
    } seq_t;

endpackage

// ===== hw/rtl/process_control_block_queue_core.sv =====
// Ordered queue of up to DEPTH process records (id, state code, timestamp),
// kept in one single-port-write, registered-read RAM and served by a small
// sequencer that walks the RAM one entry per cycle. Enqueue appends at the
// tail and hands out the next id from a wrapping 32-bit counter. Delete at
// a position reads the record, then moves every later record down one
// slot. Lookup compares stored ids against the key one per cycle from the
// head. Each step needs one registered read from the RAM. s_ready is high
// only while the sequencer is idle; a finished result sits in the output
// register, so a new beat is taken while the previous result still waits.
// Every beat gives exactly one result beat carrying a status and the
// occupancy after the operation.
module process_control_block_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [2:0]  s_state_code,
    input  logic [31:0] s_timestamp,
    input  logic [7:0]  s_position,
    input  logic [31:0] s_lookup_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_record_id,
    output logic [2:0]  m_record_state,
    output logic [31:0] m_record_time,
    output logic [8:0]  m_occupancy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer and queue bookkeeping
    pcbq_pkg::seq_t    state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [31:0]       next_id_reg, next_id_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [31:0]       key_reg, key_next;

    // Result held until the output register frees up
    pcbq_pkg::status_t res_status_reg, res_status_next;
    pcbq_pkg::rec_t    res_rec_reg, res_rec_next;

    // Output register
    logic              m_valid_reg;
    pcbq_pkg::status_t m_status_reg;
    pcbq_pkg::rec_t    m_rec_reg;
    logic [CW-1:0]     m_occ_reg;

    // RAM port
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    pcbq_pkg::rec_t    ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    pcbq_pkg::rec_t    ram_rdata;

    logic [9:0]        idx_p1;
    logic [9:0]        idx_p2;
    logic [9:0]        count_w;
    logic [2:0]        code_sat;
    logic              accept;
    logic              load_out;

    pcbq_ram #(
        .WIDTH ($bits(pcbq_pkg::rec_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == pcbq_pkg::S_IDLE);
    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == pcbq_pkg::S_FIN) && (!m_valid_reg || m_ready);

    assign idx_p1   = 10'(idx_reg) + 10'd1;
    assign idx_p2   = 10'(idx_reg) + 10'd2;
    assign count_w  = 10'(count_reg);
    // Clamp codes past the last defined state to "invalid"
    assign code_sat = (s_state_code > pcbq_pkg::STATE_INVALID) ?
                      pcbq_pkg::STATE_INVALID : s_state_code;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        next_id_next    = next_id_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;

        ram_we          = 1'b0;
        ram_waddr       = AW'(count_reg);
        ram_wdata       = '{id: next_id_reg, state_code: code_sat, timestamp: s_timestamp};
        ram_re          = 1'b0;
        ram_raddr       = AW'(idx_p1);

        case (state_reg)
            pcbq_pkg::S_IDLE: begin
                if (accept) begin
                    key_next = s_lookup_id;
                    idx_next = AW'(s_position);
                    case (s_func)
                        pcbq_pkg::FN_ENQ: begin
                            if (count_w == 10'(DEPTH)) begin
                                res_status_next = pcbq_pkg::ST_FULL;
                                res_rec_next    = pcbq_pkg::REC_ZERO;
                            end else begin
                                // Append at the tail and consume one id
                                ram_we          = 1'b1;
                                res_status_next = pcbq_pkg::ST_OK;
                                res_rec_next    = ram_wdata;
                                count_next      = count_reg + CW'(1);
                                next_id_next    = next_id_reg + 32'd1;
                            end
                            state_next = pcbq_pkg::S_FIN;
                        end
                        pcbq_pkg::FN_DEL: begin
                            if (count_reg == '0) begin
                                res_status_next = pcbq_pkg::ST_MISS;
                                res_rec_next    = pcbq_pkg::REC_ZERO;
                                state_next      = pcbq_pkg::S_FIN;
                            end else if (10'(s_position) >= count_w) begin
                                res_status_next = pcbq_pkg::ST_RANGE;
                                res_rec_next    = pcbq_pkg::REC_ZERO;
                                state_next      = pcbq_pkg::S_FIN;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(s_position);
                                state_next = pcbq_pkg::S_DCAP;
                            end
                        end
                        pcbq_pkg::FN_LOOKUP: begin
                            if (count_reg == '0) begin
                                res_status_next = pcbq_pkg::ST_MISS;
                                res_rec_next    = pcbq_pkg::REC_ZERO;
                                state_next      = pcbq_pkg::S_FIN;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = pcbq_pkg::S_LOOK;
                            end
                        end
                        default: begin
                            res_status_next = pcbq_pkg::ST_OK;
                            res_rec_next    = pcbq_pkg::REC_ZERO;
                            state_next      = pcbq_pkg::S_FIN;
                        end
                    endcase
                end
            end
            pcbq_pkg::S_DCAP: begin
                // Capture the removed record, start pulling the tail down
                res_status_next = pcbq_pkg::ST_OK;
                res_rec_next    = ram_rdata;
                if (idx_p1 < count_w) begin
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(idx_p1);
                    state_next = pcbq_pkg::S_DSHIFT;
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = pcbq_pkg::S_FIN;
                end
            end
            pcbq_pkg::S_DSHIFT: begin
                // rdata holds entry idx+1: move it into idx
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = AW'(idx_p1);
                if (idx_p2 < count_w) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(idx_p2);
                end else begin
                    count_next = count_reg - CW'(1);
                    state_next = pcbq_pkg::S_FIN;
                end
            end
            pcbq_pkg::S_LOOK: begin
                if (ram_rdata.id == key_reg) begin
                    res_status_next = pcbq_pkg::ST_OK;
                    res_rec_next    = ram_rdata;
                    state_next      = pcbq_pkg::S_FIN;
                end else if (idx_p1 < count_w) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(idx_p1);
                    idx_next  = AW'(idx_p1);
                end else begin
                    res_status_next = pcbq_pkg::ST_MISS;
                    res_rec_next    = pcbq_pkg::REC_ZERO;
                    state_next      = pcbq_pkg::S_FIN;
                end
            end
            pcbq_pkg::S_FIN: begin
                // Hold until the output register can take the result
                if (load_out) begin
                    state_next = pcbq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pcbq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pcbq_pkg::S_IDLE;
            count_reg   <= '0;
            next_id_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            next_id_reg <= next_id_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_rec_reg    <= res_rec_next;
        if (load_out) begin
            m_status_reg <= res_status_reg;
            m_rec_reg    <= res_rec_reg;
            m_occ_reg    <= count_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_record_id    = m_rec_reg.id;
    assign m_record_state = m_rec_reg.state_code;
    assign m_record_time  = m_rec_reg.timestamp;
    assign m_occupancy    = 9'(m_occ_reg);

endmodule

// ===== hw/rtl/pcbq_ram.sv =====
module pcbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== tb/process_control_block_queue_core_tb.sv =====
module process_control_block_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    // Opcode 3 has no package name; the block treats it as a no-op.
    localparam pcbq_pkg::func_t FN_NOP = 2'd3;

    // Receiver back-pressure stretch, end-of-run settle time and hang limit.
    // The hang limit covers the long hold-off plus the longest random gaps on
    // both sides.
    localparam int LONG_HOLD      = 500;
    localparam int SETTLE_CYCLES  = 3 * (DEPTH + 2);
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        pcbq_pkg::func_t func;
        logic [2:0]      state_code;
        logic [31:0]     timestamp;
        logic [7:0]      position;
        logic [31:0]     lookup_id;
    } pcb_op_t;

    typedef struct {
        pcbq_pkg::status_t status;
        logic [31:0]       rec_id;
        logic [2:0]        rec_state;
        logic [31:0]       rec_time;
        logic [8:0]        occ;
    } pcb_result_t;

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func         = pcbq_pkg::FN_ENQ;
    logic [2:0]  s_state_code   = 3'd0;
    logic [31:0] s_timestamp    = 32'd0;
    logic [7:0]  s_position     = 8'd0;
    logic [31:0] s_lookup_id    = 32'd0;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_record_id;
    logic [2:0]  m_record_state;
    logic [31:0] m_record_time;
    logic [8:0]  m_occupancy;

    process_control_block_queue_core #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_state_code  (s_state_code),
        .s_timestamp   (s_timestamp),
        .s_position    (s_position),
        .s_lookup_id   (s_lookup_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_record_id   (m_record_id),
        .m_record_state(m_record_state),
        .m_record_time (m_record_time),
        .m_occupancy   (m_occupancy)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Operations waiting to go out, and results the queue must still return.
    pcb_op_t     pcb_ops_todo[$];
    pcb_result_t expected_pcb_results[$];

    // Idle odds in percent, changed only between phases on a falling edge.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_armed = 1'b0;

    int unsigned mismatch_count = 0;
    int unsigned results_checked = 0;
    int unsigned ops_accepted = 0;

    // ------------------------------------------------------------------
    // Shadow of the record queue: the predictor's own copy of the RAM,
    // the occupancy and the id counter.
    // ------------------------------------------------------------------
    logic [31:0] shadow_ids[DEPTH];
    logic [2:0]  shadow_states[DEPTH];
    logic [31:0] shadow_times[DEPTH];
    int          shadow_count = 0;
    logic [31:0] shadow_next_id = 32'd0;
    int unsigned status_hits[4] = '{0, 0, 0, 0};
    int          peak_count = 0;

    // Apply one operation to the shadow queue and return the result beat
    // the block must produce for it.
    function automatic pcb_result_t pcb_queue_predict(pcb_op_t op);
        pcb_result_t r;
        logic [2:0]  code;
        int          pos;
        bit          found;
        r = '{status: pcbq_pkg::ST_OK, rec_id: 32'd0, rec_state: 3'd0,
              rec_time: 32'd0, occ: 9'd0};
        case (op.func)
            pcbq_pkg::FN_ENQ: begin
                // Codes above "invalid" are clamped to it.
                code = (op.state_code > pcbq_pkg::STATE_INVALID) ?
                       pcbq_pkg::STATE_INVALID : op.state_code;
                if (shadow_count >= DEPTH) begin
                    // Refused: no id consumed, record fields zero.
                    r.status = pcbq_pkg::ST_FULL;
                end else begin
                    shadow_ids[shadow_count]    = shadow_next_id;
                    shadow_states[shadow_count] = code;
                    shadow_times[shadow_count]  = op.timestamp;
                    shadow_count++;
                    r.rec_id       = shadow_next_id;
                    r.rec_state    = code;
                    r.rec_time     = op.timestamp;
                    shadow_next_id = shadow_next_id + 32'd1;
                end
            end
            pcbq_pkg::FN_DEL: begin
                pos = op.position;
                if (shadow_count == 0) begin
                    r.status = pcbq_pkg::ST_MISS;
                end else if (pos >= shadow_count) begin
                    r.status = pcbq_pkg::ST_RANGE;
                end else begin
                    r.rec_id    = shadow_ids[pos];
                    r.rec_state = shadow_states[pos];
                    r.rec_time  = shadow_times[pos];
                    // Close the gap: every later record moves down one slot.
                    for (int i = pos; i < shadow_count - 1; i++) begin
                        shadow_ids[i]    = shadow_ids[i + 1];
                        shadow_states[i] = shadow_states[i + 1];
                        shadow_times[i]  = shadow_times[i + 1];
                    end
                    shadow_count--;
                end
            end
            pcbq_pkg::FN_LOOKUP: begin
                // First match counted from the head wins.
                found = 1'b0;
                for (int i = 0; i < shadow_count; i++) begin
                    if (!found && shadow_ids[i] == op.lookup_id) begin
                        found       = 1'b1;
                        r.rec_id    = shadow_ids[i];
                        r.rec_state = shadow_states[i];
                        r.rec_time  = shadow_times[i];
                    end
                end
                if (!found)
                    r.status = pcbq_pkg::ST_MISS;
            end
            default: begin
                // No-op code: status ok, nothing touched.
            end
        endcase
        r.occ = 9'(shadow_count);
        status_hits[r.status]++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next operation when the channel is free, hold
    // the beat until it is taken, and predict each beat as it is accepted.
    // ------------------------------------------------------------------
    pcb_op_t on_bus;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_pcb_results.insert(expected_pcb_results.size(),
                                            pcb_queue_predict(on_bus));
                ops_accepted++;
            end
            // Advance only when nothing is on the bus or the beat just went.
            if (!s_valid || s_ready) begin
                if (pcb_ops_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_bus       = pcb_ops_todo.pop_front();
                    s_valid      <= 1'b1;
                    s_func       <= on_bus.func;
                    s_state_code <= on_bus.state_code;
                    s_timestamp  <= on_bus.timestamp;
                    s_position   <= on_bus.position;
                    s_lookup_id  <= on_bus.lookup_id;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check every result beat against the oldest expectation,
    // then decide whether to stall the next cycle.
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: result %0d field %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, results_checked, name, want, got);
            mismatch_count++;
        end
    endtask

    int unsigned hold_count = 0;

    always @(posedge aclk) begin
        pcb_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_pcb_results.size() == 0) begin
                    $display("%0t ns: unexpected result beat, status %0d id 0x%0h occupancy %0d",
                             $time, m_status, m_record_id, m_occupancy);
                    mismatch_count++;
                end else begin
                    want = expected_pcb_results.pop_front();
                    check_field("status",       want.status,    m_status);
                    check_field("record_id",    want.rec_id,    m_record_id);
                    check_field("record_state", want.rec_state, m_record_state);
                    check_field("record_time",  want.rec_time,  m_record_time);
                    check_field("occupancy",    want.occ,       m_occupancy);
                end
                results_checked++;
            end
            // Once armed, drop ready for one long stretch so the block backs up.
            if (hold_armed && hold_count < LONG_HOLD) begin
                hold_count++;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if no beat moves on either side for too long.
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no beat for %0d cycles, %0d ops queued, %0d results owed",
                     $time, quiet_cycles, pcb_ops_todo.size(), expected_pcb_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [31:0] ids_issued = 32'd0;   // rough count of ids handed out so far
    bit          filling = 1'b0;
    int          burst_left = 0;

    task automatic push_op(pcbq_pkg::func_t f, logic [2:0] code, logic [31:0] ts,
                           logic [7:0] pos, logic [31:0] key);
        pcb_op_t op;
        op = '{func: f, state_code: code, timestamp: ts, position: pos, lookup_id: key};
        pcb_ops_todo.insert(pcb_ops_todo.size(), op);
    endtask

    // Alternate fill and drain bursts so the queue swings between empty and
    // full; lookups mostly aim at recently issued ids so that most of them hit.
    task automatic push_random_ops(int n);
        pcb_op_t op;
        int      pick;
        int      sel;
        repeat (n) begin
            if (burst_left == 0) begin
                filling    = !filling;
                burst_left = $urandom_range(8, 40);
            end
            burst_left--;
            op.state_code = 3'($urandom_range(0, 7));
            op.timestamp  = $urandom;
            sel = $urandom_range(99);
            if (sel < 40)
                op.position = 8'd0;
            else if (sel < 85)
                op.position = 8'($urandom_range(0, DEPTH - 1));
            else
                op.position = 8'($urandom_range(0, 255));
            if ($urandom_range(99) < 75)
                op.lookup_id = ids_issued - 32'($urandom_range(1, DEPTH + 4));
            else
                op.lookup_id = $urandom;
            pick = $urandom_range(99);
            if (pick < 4)
                op.func = FN_NOP;
            else if (filling)
                op.func = (pick < 70) ? pcbq_pkg::FN_ENQ :
                          (pick < 85) ? pcbq_pkg::FN_LOOKUP : pcbq_pkg::FN_DEL;
            else
                op.func = (pick < 25) ? pcbq_pkg::FN_ENQ :
                          (pick < 40) ? pcbq_pkg::FN_LOOKUP : pcbq_pkg::FN_DEL;
            if (op.func == pcbq_pkg::FN_ENQ)
                ids_issued = ids_issued + 32'd1;
            pcb_ops_todo.insert(pcb_ops_todo.size(), op);
        end
    endtask

    // Wait until every queued operation has been sent and its result has come back.
    task automatic wait_quiet();
        while (pcb_ops_todo.size() != 0 || s_valid || expected_pcb_results.size() != 0)
            @(negedge aclk);
    endtask

    task automatic run_phase(int unsigned send_pct, int unsigned recv_pct, int n);
        @(negedge aclk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        push_random_ops(n);
        wait_quiet();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty-queue cases and the no-op code first.
        push_op(pcbq_pkg::FN_DEL,    3'd0, 32'd0, 8'd255, 32'd0);
        push_op(pcbq_pkg::FN_LOOKUP, 3'd0, 32'd0, 8'd0,   32'd0);
        push_op(FN_NOP,              3'd7, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
        // Fill to the brim, walking every state code including the clamped ones.
        for (int i = 0; i < DEPTH; i++)
            push_op(pcbq_pkg::FN_ENQ, 3'(i),
                    (i == 0) ? 32'd0 : (i == 1) ? 32'hFFFF_FFFF : $urandom,
                    8'd0, 32'd0);
        ids_issued = 32'(DEPTH);
        // Refused append, then hits at head and tail and a miss.
        push_op(pcbq_pkg::FN_ENQ,    3'd2, 32'h1234_5678, 8'd0, 32'd0);
        push_op(pcbq_pkg::FN_LOOKUP, 3'd0, 32'd0, 8'd0, 32'd0);
        push_op(pcbq_pkg::FN_LOOKUP, 3'd0, 32'd0, 8'd0, 32'(DEPTH - 1));
        push_op(pcbq_pkg::FN_LOOKUP, 3'd0, 32'd0, 8'd0, 32'hFFFF_FFFF);
        // Out of range, tail, head and middle deletes.
        push_op(pcbq_pkg::FN_DEL, 3'd0, 32'd0, 8'(DEPTH), 32'd0);
        push_op(pcbq_pkg::FN_DEL, 3'd0, 32'd0, 8'(DEPTH - 1), 32'd0);
        push_op(pcbq_pkg::FN_DEL, 3'd0, 32'd0, 8'd0, 32'd0);
        push_op(pcbq_pkg::FN_DEL, 3'd0, 32'd0, 8'd5, 32'd0);
        wait_quiet();

        // Random phases: clean bus, slow sender, slow receiver, both.
        run_phase(0,  0,  400);
        run_phase(75, 0,  350);
        run_phase(0,  75, 350);
        run_phase(22, 22, 350);

        // Back-pressure: hold the receiver off while the sender keeps offering.
        @(negedge aclk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_armed     = 1'b1;
        push_random_ops(60);
        wait_quiet();

        // Let any stray late beat show up before judging.
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Run covered %0d operations and %0d results, peak occupancy %0d of %0d.",
                 ops_accepted, results_checked, peak_count, DEPTH);
        $display("Status mix: ok %0d, full %0d, miss %0d, out of range %0d.",
                 status_hits[pcbq_pkg::ST_OK], status_hits[pcbq_pkg::ST_FULL],
                 status_hits[pcbq_pkg::ST_MISS], status_hits[pcbq_pkg::ST_RANGE]);
        if (mismatch_count == 0 && expected_pcb_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
